// ----- rtl/ils_pkg.sv -----
// Package of shared types and constants for the indexed list store.
`default_nettype none

package ils_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int ELEM_WIDTH_DEF = 32;

	localparam int ACTION_W = 3;
	localparam int POS_W    = 5;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int FPOS_W   = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_GET    = 3'd3,
		ACT_SET    = 3'd4,
		ACT_FIND   = 3'd5,
		ACT_CLEAR  = 3'd6
	} act_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// What a cell loads on a clock edge.
	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_LOAD  = 2'd1,
		SEL_LEFT  = 2'd2,
		SEL_RIGHT = 2'd3
	} cell_sel_t;

	// List-wide operation that every cell decodes against its own position.
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_APPEND = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_SET    = 3'd4
	} list_op_t;

	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   value;
		logic                found;
		logic [FPOS_W-1:0]   found_position;
		logic [COUNT_W-1:0]  count;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/ils_cell.sv -----
// One storage cell of the list: a word register with a neighbor mux and an equality compare.
`default_nettype none

module ils_cell
	import ils_pkg::*;
#(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire cell_sel_t             sel,
	input  wire logic [ELEM_WIDTH-1:0] load_word,
	input  wire logic [ELEM_WIDTH-1:0] left_word,
	input  wire logic [ELEM_WIDTH-1:0] right_word,
	output logic      [ELEM_WIDTH-1:0] word,
	output logic                       match
);

	logic [ELEM_WIDTH-1:0] word_q;

	// Payload only, so no reset is needed.
	always_ff @(posedge clk) begin
		case (sel)
			SEL_LOAD:  word_q <= load_word;
			SEL_LEFT:  word_q <= left_word;
			SEL_RIGHT: word_q <= right_word;
			default:   word_q <= word_q;
		endcase
	end

	assign word  = word_q;
	assign match = (word_q == load_word);

endmodule

`default_nettype wire

// ----- rtl/ils_outbuf.sv -----
// Two-entry result buffer: an output register with a skid stage behind it.
`default_nettype none

module ils_outbuf
	import ils_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_res,
	output logic         full,
	output logic         out_valid,
	input  wire logic    out_stall,
	output result_t      out_res
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q || pop) begin
				if (skid_valid_q) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	// A new beat is refused only while the skid stage is occupied.
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

endmodule

`default_nettype wire

// ----- rtl/indexed_list_store.sv -----
// Top level of the indexed list store: control decode, the row of cells and the result buffer.
// Each accepted request's result is registered into the result buffer, which offers it downstream.
// Throughput is one request per cycle while in_stall is low; every list action, including insert
// and remove with their full-row shifts and find with its parallel compare, completes on acceptance.
// A two-entry result buffer lets one further request in while a result waits downstream.
// Reset clears the entry count and the result buffer; cell contents are undefined until written.
`default_nettype none

module indexed_list_store
	import ils_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [POS_W-1:0]    position,
	input  wire logic [WORD_W-1:0]   element,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [WORD_W-1:0]        value,
	output logic                     found,
	output logic [FPOS_W-1:0]        found_position,
	output logic [COUNT_W-1:0]       count
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  accept;
	logic                  buf_full;
	logic [ELEM_WIDTH-1:0] word_in;
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      cnt_ext;
	logic [IDX_W-1:0]      pos_idx;
	list_op_t              op_c;
	status_t               status_c;
	logic                  read_en;
	logic                  find_en;
	logic                  hit;
	logic [IDX_W-1:0]      hit_idx;
	result_t               res_c;
	result_t               res_out;

	logic [ELEM_WIDTH-1:0] cell_word [DEPTH];
	logic [DEPTH-1:0]      cell_match;

	// The input side stalls only when both result slots are taken.
	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	// Only the low ELEM_WIDTH bits of the element take part in storage and compares.
	assign word_in = ELEM_WIDTH'(element);
	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign pos_idx = pos_ext[IDX_W-1:0];

	// Request decode. The row operation tells each cell how to move; the status and the
	// count follow the list semantics, with the range check taking priority over full.
	always_comb begin
		op_c     = OP_NONE;
		status_c = ST_OK;
		read_en  = 1'b0;
		find_en  = 1'b0;
		count_d  = count_q;
		case (action)
			ACT_APPEND: begin
				if (count_q == FULL_COUNT) begin
					status_c = ST_FULL;
				end else begin
					op_c    = OP_APPEND;
					count_d = CNT_W'(count_q + 1'b1);
				end
			end
			ACT_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_c = ST_BAD_INDEX;
				end else if (count_q == FULL_COUNT) begin
					status_c = ST_FULL;
				end else begin
					op_c    = OP_INSERT;
					count_d = CNT_W'(count_q + 1'b1);
				end
			end
			ACT_REMOVE: begin
				if (pos_ext >= cnt_ext) begin
					status_c = ST_BAD_INDEX;
				end else begin
					op_c    = OP_REMOVE;
					read_en = 1'b1;
					count_d = CNT_W'(count_q - 1'b1);
				end
			end
			ACT_GET: begin
				if (pos_ext >= cnt_ext) begin
					status_c = ST_BAD_INDEX;
				end else begin
					read_en = 1'b1;
				end
			end
			ACT_SET: begin
				if (pos_ext >= cnt_ext) begin
					status_c = ST_BAD_INDEX;
				end else begin
					op_c = OP_SET;
				end
			end
			ACT_FIND: begin
				find_en = 1'b1;
			end
			ACT_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// The row of cells. Each cell decides its own move from its position relative to the
	// request position and the count: insert shifts the tail up one cell, remove shifts it
	// down one cell, append and set load a single cell.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CMP_W-1:0] CELL_POS = CMP_W'(i);

		cell_sel_t             sel;
		logic [ELEM_WIDTH-1:0] left_word;
		logic [ELEM_WIDTH-1:0] right_word;

		if (i == 0) begin : g_first
			assign left_word = word_in;
		end else begin : g_inner_left
			assign left_word = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_word = cell_word[i];
		end else begin : g_inner_right
			assign right_word = cell_word[i+1];
		end

		always_comb begin
			sel = SEL_HOLD;
			if (accept) begin
				case (op_c)
					OP_APPEND: if (CELL_POS == cnt_ext) sel = SEL_LOAD;
					OP_INSERT: begin
						if (CELL_POS == pos_ext) begin
							sel = SEL_LOAD;
						end else if (CELL_POS > pos_ext) begin
							sel = SEL_LEFT;
						end
					end
					OP_REMOVE: if (CELL_POS >= pos_ext) sel = SEL_RIGHT;
					OP_SET:    if (CELL_POS == pos_ext) sel = SEL_LOAD;
					default:   sel = SEL_HOLD;
				endcase
			end
		end

		logic match_raw;

		ils_cell #(
			.ELEM_WIDTH(ELEM_WIDTH)
		) u_cell (
			.clk       (clk),
			.sel       (sel),
			.load_word (word_in),
			.left_word (left_word),
			.right_word(right_word),
			.word      (cell_word[i]),
			.match     (match_raw)
		);

		// Cells at or beyond the count hold stale words and never match.
		assign cell_match[i] = match_raw && (CELL_POS < cnt_ext);
	end

	// Priority pick of the lowest matching cell.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_match[IDX_W'(i)]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		res_c.status         = status_c;
		res_c.value          = read_en ? WORD_W'(cell_word[pos_idx]) : '0;
		res_c.found          = find_en && hit;
		res_c.found_position = (find_en && hit) ? FPOS_W'(hit_idx) : '0;
		res_c.count          = COUNT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	ils_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_res (res_c),
		.full     (buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (res_out)
	);

	assign status         = res_out.status;
	assign value          = res_out.value;
	assign found          = res_out.found;
	assign found_position = res_out.found_position;
	assign count          = res_out.count;

endmodule

`default_nettype wire

// ----- sim/ils_checker.sv -----
// Watches both channels of the indexed list store, predicts every result beat and compares it.
`timescale 1ns / 100ps

module ils_checker
	import ils_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [POS_W-1:0]    position,
	input  logic [WORD_W-1:0]   element,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [WORD_W-1:0]   value,
	input  logic                found,
	input  logic [FPOS_W-1:0]   found_position,
	input  logic [COUNT_W-1:0]  count,
	output int                  errors,
	output int                  pending
);

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	logic [WORD_W-1:0]  cells [LIST_DEPTH];
	logic [COUNT_W-1:0] list_len;
	result_t            due_results [$];
	result_t            want;

	// Applies one request to the shadow list and returns the result it should produce.
	function automatic result_t apply_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
			logic [WORD_W-1:0] word);
		result_t r;
		int      k;
		r = '0;
		case (act)
			ACT_APPEND: begin
				if (list_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					cells[list_len[IDX_W-1:0]] = word;
					list_len = list_len + 1'b1;
				end
			end
			ACT_INSERT: begin
				if (pos > list_len) begin
					r.status = ST_BAD_INDEX;
				end else if (list_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (k = int'(list_len); k > int'(pos); k--)
						cells[IDX_W'(k)] = cells[IDX_W'(k - 1)];
					cells[pos[IDX_W-1:0]] = word;
					list_len = list_len + 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (pos >= list_len) begin
					r.status = ST_BAD_INDEX;
				end else begin
					r.value = cells[pos[IDX_W-1:0]];
					for (k = int'(pos); k + 1 < int'(list_len); k++)
						cells[IDX_W'(k)] = cells[IDX_W'(k + 1)];
					list_len = list_len - 1'b1;
				end
			end
			ACT_GET: begin
				if (pos >= list_len)
					r.status = ST_BAD_INDEX;
				else
					r.value = cells[pos[IDX_W-1:0]];
			end
			ACT_SET: begin
				if (pos >= list_len)
					r.status = ST_BAD_INDEX;
				else
					cells[pos[IDX_W-1:0]] = word;
			end
			ACT_FIND: begin
				for (k = 0; k < int'(list_len); k++) begin
					if (!r.found && cells[IDX_W'(k)] == word) begin
						r.found = 1'b1;
						r.found_position = k[FPOS_W-1:0];
					end
				end
			end
			ACT_CLEAR: begin
				list_len = '0;
			end
			default: begin
			end
		endcase
		r.count = list_len;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] want_v,
			input logic [WORD_W-1:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t ils_checker: %s expected %0h actual %0h", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			list_len = '0;
			pending  = 0;
			errors   = 0;
		end else begin
			// The result side is handled first: a result never belongs to a request of the same edge.
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t ils_checker: result beat with none expected, count %0h",
						$time, count);
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, status);
					check_field("value", want.value, value);
					check_field("found", want.found, found);
					check_field("found_position", want.found_position, found_position);
					check_field("count", want.count, count);
				end
			end
			if (in_valid && !in_stall)
				due_results.push_back(apply_request(action, position, element));
			pending = due_results.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// Top of the indexed list store testbench: clock, reset, request stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps

module tb;
	import ils_pkg::*;

	// Action code 7 is outside the decoded set; the block must answer it without touching the list.
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_BEATS = 475;
	// Watchdog limit on the whole run; a correct run ends before it, even in the slowest idling phase.
	localparam int LIMIT = 100000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [ACTION_W-1:0] action;
	logic [POS_W-1:0]    position;
	logic [WORD_W-1:0]   element;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   value;
	logic                found;
	logic [FPOS_W-1:0]   found_position;
	logic [COUNT_W-1:0]  count;

	int errors;
	int pending;
	int cycles = 0;

	// Sender idle and receiver stall rates, in percent, for the running phase.
	int idle_pct  = 0;
	int stall_pct = 0;

	// Long receiver hold-offs are asked for by bumping holds_asked; the receiver counts them out.
	int holds_asked = 0;
	int holds_done  = 0;
	int hold_left   = 0;

	// Rough length of the list as the sender sees it, used only to aim positions at real entries.
	int fill = 0;

	// A small pool of words so that finds hit and duplicates show up in the list.
	logic [WORD_W-1:0] word_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
		32'h5A5A_5A5A, 32'h0000_0001, 32'h8000_0000, 32'h1234_5678, 32'hDEAD_BEEF};

	indexed_list_store u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.position       (position),
		.element        (element),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.value          (value),
		.found          (found),
		.found_position (found_position),
		.count          (count)
	);

	ils_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.position       (position),
		.element        (element),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.value          (value),
		.found          (found),
		.found_position (found_position),
		.count          (count),
		.errors         (errors),
		.pending        (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// The receiver either counts out a long hold-off or stalls at random at the phase's rate.
	// During a hold-off the sender keeps offering beats, so the result buffer fills and the
	// block has to stall its input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_asked) begin
			out_stall  <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Offers one request beat and returns at the edge that accepts it. Idle cycles may come
	// first. Stall is looked at on the falling edge, where every signal has settled, so the
	// decision never depends on event order at the rising edge.
	task automatic put_beat(input logic [ACTION_W-1:0] a, input logic [POS_W-1:0] p,
			input logic [WORD_W-1:0] e);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= a;
		position <= p;
		element  <= e;
		case (a)
			ACT_APPEND: if (fill < LIST_DEPTH) fill++;
			ACT_INSERT: if (p <= fill && fill < LIST_DEPTH) fill++;
			ACT_REMOVE: if (p < fill) fill--;
			ACT_CLEAR:  fill = 0;
			default: begin
			end
		endcase
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Stops offering and waits until every result that was asked for has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		int                  ph;
		int                  i;
		int                  r;
		int                  w_add;
		int                  w_rm;
		int                  bias;
		int                  idle_set [4];
		int                  stall_set [4];
		logic [ACTION_W-1:0] a;
		logic [POS_W-1:0]    p;
		logic [WORD_W-1:0]   e;

		idle_set  = '{0, 46, 0, 8};
		stall_set = '{0, 0, 46, 8};
		bias      = 2;

		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		action   <= ACT_APPEND;
		position <= '0;
		element  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: get, remove, set and find on an empty list, the unused code, the edges of the
		// insert range, reads at and past the count, duplicate words for find, and a clear.
		put_beat(ACT_GET, 5'd0, 32'h0);
		put_beat(ACT_REMOVE, 5'd0, 32'h0);
		put_beat(ACT_SET, 5'd0, 32'h1);
		put_beat(ACT_FIND, 5'd0, 32'h0);
		put_beat(ACT_UNUSED, 5'd31, 32'hFFFF_FFFF);
		put_beat(ACT_APPEND, 5'd0, 32'h0000_0000);
		put_beat(ACT_APPEND, 5'd31, 32'hFFFF_FFFF);
		put_beat(ACT_INSERT, 5'd0, 32'hA5A5_A5A5);
		put_beat(ACT_INSERT, 5'd3, 32'h5A5A_5A5A);
		put_beat(ACT_INSERT, 5'd6, 32'h1234_5678);
		put_beat(ACT_INSERT, 5'd16, 32'h1234_5678);
		put_beat(ACT_GET, 5'd0, 32'h0);
		put_beat(ACT_GET, 5'd3, 32'h0);
		put_beat(ACT_GET, 5'd4, 32'h0);
		put_beat(ACT_SET, 5'd1, 32'hDEAD_BEEF);
		put_beat(ACT_APPEND, 5'd0, 32'hA5A5_A5A5);
		put_beat(ACT_FIND, 5'd0, 32'hA5A5_A5A5);
		put_beat(ACT_FIND, 5'd0, 32'hFFFF_FFFF);
		put_beat(ACT_FIND, 5'd0, 32'h8000_0000);
		put_beat(ACT_REMOVE, 5'd0, 32'h0);
		put_beat(ACT_REMOVE, 5'd31, 32'h0);
		put_beat(ACT_REMOVE, 5'd3, 32'h0);
		put_beat(ACT_CLEAR, 5'd7, 32'h0);
		put_beat(ACT_GET, 5'd0, 32'h0);
		wait_drained();

		// Random part in four idling phases. Requests mostly aim at real positions, and the mix
		// drifts between growing and shrinking so the list keeps running full and empty.
		for (ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_set[ph];
			stall_pct <= stall_set[ph];
			for (i = 0; i < PHASE_BEATS; i++) begin
				if (ph == 0 && i == 120)
					holds_asked <= holds_asked + 1;
				if (i % 48 == 0)
					bias = $urandom_range(2);
				w_add = (bias == 2) ? 55 : (bias == 1) ? 30 : 12;
				w_rm  = (bias == 0) ? 40 : (bias == 1) ? 20 : 8;
				r = $urandom_range(99);
				if (r < 1)
					a = ACT_CLEAR;
				else if (r < 2)
					a = ACT_UNUSED;
				else if (r < 2 + w_add)
					a = $urandom_range(1) ? ACT_APPEND : ACT_INSERT;
				else if (r < 2 + w_add + w_rm)
					a = ACT_REMOVE;
				else begin
					case ($urandom_range(2))
						0:       a = ACT_GET;
						1:       a = ACT_SET;
						default: a = ACT_FIND;
					endcase
				end
				if ($urandom_range(9) == 0)
					p = POS_W'($urandom_range(31));
				else if (a == ACT_INSERT)
					p = POS_W'($urandom_range(fill));
				else
					p = (fill > 0) ? POS_W'($urandom_range(fill - 1)) : '0;
				if ($urandom_range(99) < ((a == ACT_FIND) ? 70 : 40))
					e = word_pool[3'($urandom_range(7))];
				else
					e = $urandom;
				put_beat(a, p, e);
			end
			// The sender pauses here until the block has answered everything.
			wait_drained();
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/ils_outbuf.sv
rtl/indexed_list_store.sv
sim/ils_checker.sv
sim/tb.sv
